// ===== rtl/qnts_pkg.sv =====
// Package for the queued note tone sequencer.
// Holds queue entry, control structs, opcode constants and the note decoder.
// No dependencies.
package qnts_pkg;

  // Opcode values on the input channel
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // One queued note: code and length in ticks
  typedef struct packed {
    logic [7:0] code;
    logic [7:0] len;
  } qnts_entry_t;

  // Queue command from the sequencer to the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } qnts_cmd_t;

  // Queue status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } qnts_status_t;

  // Per-cell load controls
  typedef struct packed {
    logic shift;
    logic load;
  } qnts_cell_ctrl_t;

  // Decoded tone setting
  typedef struct packed {
    logic [13:0] freq;
    logic [7:0]  duty;
    logic        dbl;
  } qnts_tone_t;

  // Top-octave base frequencies, scaled by 2 to the fifth
  function automatic logic [14:0] freq_base(input logic [3:0] n);
    logic [14:0] f;
    case (n)
      4'd0:    f = 15'd16744;
      4'd1:    f = 15'd17740;
      4'd2:    f = 15'd18795;
      4'd3:    f = 15'd19912;
      4'd4:    f = 15'd21096;
      4'd5:    f = 15'd22351;
      4'd6:    f = 15'd23680;
      4'd7:    f = 15'd25088;
      4'd8:    f = 15'd26579;
      4'd9:    f = 15'd28160;
      4'd10:   f = 15'd29834;
      4'd11:   f = 15'd31608;
      default: f = 15'd0;
    endcase
    return f;
  endfunction

  // Decode a note code into frequency, duty and amplitude flag
  function automatic qnts_tone_t decode_note(input logic [7:0] code);
    logic [1:0]  vol;
    logic [2:0]  oct;
    logic [3:0]  n;
    logic [14:0] shifted;
    qnts_tone_t  t;
    vol = code[7:6];
    oct = {1'b0, code[5:4]};
    n   = code[3:0];
    // Notes past the octave wrap into the next one
    if (n >= 4'd12) begin
      n   = n - 4'd12;
      oct = oct + 3'd1;
    end
    shifted = freq_base(n) >> (3'd5 - oct);
    t.freq  = (vol == 2'd0) ? 14'd0 : shifted[13:0];
    t.duty  = (vol == 2'd0) ? 8'd0 : (8'd16 << vol);
    t.dbl   = (vol == 2'd3);
    return t;
  endfunction

endpackage

// ===== rtl/qnts_cell.sv =====
// One storage cell of the note queue chain.
// Depends on qnts_pkg for the entry and control types.
module qnts_cell
  import qnts_pkg::*;
(
  input  logic            clk_i,
  input  qnts_cell_ctrl_t ctrl_i,
  input  qnts_entry_t     next_i,
  input  qnts_entry_t     new_i,
  output qnts_entry_t     data_o
);

  qnts_entry_t data_q;

  // Take the neighbor's entry on a pop, the new entry when this cell is the tail
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= next_i;
    end else if (ctrl_i.load) begin
      data_q <= new_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/qnts_chain.sv =====
// Note queue built as a row of cells that shift toward the head on a pop.
// Depends on qnts_pkg and qnts_cell.
module qnts_chain
  import qnts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  qnts_cmd_t    cmd_i,
  input  qnts_entry_t  push_data_i,
  output qnts_entry_t  head_o,
  output qnts_status_t status_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  qnts_entry_t     cell_data [QUEUE_DEPTH];

  // Fill count: cells below it hold queued notes, head at cell zero
  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Row of cells, each fed by its right-hand neighbor; the last cell feeds back its own entry
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    qnts_cell_ctrl_t ctrl;
    qnts_entry_t     next;

    assign ctrl.shift = cmd_i.pop;
    assign ctrl.load  = cmd_i.push && (count_q == CntW'(i));

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next = cell_data[i];
    end else begin : g_mid
      assign next = cell_data[i+1];
    end

    qnts_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .next_i (next),
      .new_i  (push_data_i),
      .data_o (cell_data[i])
    );
  end

  assign head_o         = cell_data[0];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(QUEUE_DEPTH));

  // Checks on the queue control
  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.pop))
    else $error("push and pop in the same cycle");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !status_o.empty)
    else $error("pop from empty queue");
  a_push_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !status_o.full)
    else $error("push into full queue");

endmodule

// ===== rtl/queued_note_tone_sequencer_unit.sv =====
// Each accepted input's result is registered in the output register.
// Throughput: one item per cycle while the output side takes each result.
// Queue pops shift the whole cell row in the same cycle, so no item waits on the queue.
// Reset (rst_ni low, asynchronous) empties the queue, clears note, timer and valid.
// Depends on qnts_pkg and qnts_chain.
module queued_note_tone_sequencer_unit
  import qnts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  note_code_i,
  input  logic [7:0]  duration_i,
  input  logic [7:0]  elapsed_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] tone_freq_o,
  output logic [7:0]  tone_duty_o,
  output logic        double_amplitude_o,
  output logic [7:0]  playing_note_o,
  output logic [7:0]  remaining_time_o,
  output logic        queue_dropped_o
);

  logic         out_valid_q;
  logic [7:0]   note_q, note_d;
  logic [7:0]   time_q, time_d;
  logic         accept, is_tick;
  logic [8:0]   diff;
  logic [7:0]   cnt_sub, cnt_fin, note_tick;
  qnts_cmd_t    cmd;
  qnts_entry_t  head, push_data;
  qnts_status_t status;
  qnts_tone_t   tone_d, tone_q;
  logic [7:0]   res_note_q, res_time_q;
  logic         dropped_d, dropped_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (opcode_i == OP_TICK);

  // Count down the current note, saturating at zero
  assign diff    = {1'b0, time_q} - {1'b0, elapsed_ticks_i};
  assign cnt_sub = (time_q == 8'd0 || diff[8]) ? 8'd0 : diff[7:0];

  // Enqueue notes, and on a tick start the next queued note when time is used up
  always_comb begin
    cmd.push       = accept && !is_tick && !status.full;
    cmd.pop        = accept && is_tick && (cnt_sub == 8'd0) && !status.empty;
    push_data.code = note_code_i;
    push_data.len  = duration_i;
    cnt_fin        = cmd.pop ? head.len : cnt_sub;
    if (cnt_fin == 8'd0) begin
      note_tick = 8'd0;
    end else if (cmd.pop) begin
      note_tick = head.code;
    end else begin
      note_tick = note_q;
    end
    note_d    = is_tick ? note_tick : note_q;
    time_d    = is_tick ? cnt_fin : time_q;
    dropped_d = !is_tick && status.full;
    tone_d    = decode_note(note_d);
  end

  qnts_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .push_data_i (push_data),
    .head_o      (head),
    .status_o    (status)
  );

  // Sequencer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_q      <= 8'd0;
      time_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        note_q <= note_d;
        time_q <= time_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tone_q     <= tone_d;
      res_note_q <= note_d;
      res_time_q <= time_d;
      dropped_q  <= dropped_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tone_freq_o        = tone_q.freq;
  assign tone_duty_o        = tone_q.duty;
  assign double_amplitude_o = tone_q.dbl;
  assign playing_note_o     = res_note_q;
  assign remaining_time_o   = res_time_q;
  assign queue_dropped_o    = dropped_q;

  // Checks on the sequencer
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q == 8'd0) |-> (note_q == 8'd0))
    else $error("note left sounding with no time");
  a_out_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && remaining_time_o == 8'd0) |-> (tone_freq_o == 14'd0))
    else $error("tone reported with no time left");
  a_drop_enqueue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_tick) |=> !queue_dropped_o)
    else $error("drop flag on a tick result");

endmodule
